// ===== hw/rtl/rtcc_pkg.sv =====
// Types and codes shared by the region table coverage checker.
// No dependencies.
`default_nettype none
package rtcc_pkg;
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RANGE = 2'd2,
    OP_LEAF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_WRAP = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  category;
    logic [63:0] virt_addr;
    logic [63:0] virt_len;
    logic [63:0] phys_addr;
    logic [63:0] phys_len;
  } req_t;

  typedef struct packed {
    logic       covered;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_STEP,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rtcc_req_if.sv =====
// Valid/ready channel interface for request words.
// Depends on rtcc_pkg.
`default_nettype none
interface rtcc_req_if import rtcc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtcc_rsp_if.sv =====
// Valid/ready channel interface for response words.
// Depends on rtcc_pkg.
`default_nettype none
interface rtcc_rsp_if import rtcc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtcc_queue.sv =====
// Two-entry request queue between the front and the back.
// Depends on rtcc_pkg and rtcc_req_if.
`default_nettype none
module rtcc_queue import rtcc_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  rtcc_req_if.sink   in_ch,
  rtcc_req_if.source out_ch
);
  req_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ch.ready  = (count != 2'd2);
  assign out_ch.valid = (count != 2'd0);
  assign out_ch.data  = mem[rptr];
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  // hold words and advance pointers
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_ch.data;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rtcc_engine.sv =====
// Back part: region table memory and the scan sequencer for queries.
// Depends on rtcc_pkg and both channel interfaces.
`default_nettype none
module rtcc_engine import rtcc_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  rtcc_req_if.sink   req,
  rtcc_rsp_if.source rsp
);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = 6 + 4 * 64;

  logic [EW-1:0] table_mem [MAX_ENTRIES];
  logic [EW-1:0] rd;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  req_t          cur;
  logic [63:0]   cur_v;
  logic [63:0]   cur_p;
  logic [63:0]   end_v;
  state_t        state;
  state_t        state_next;
  rsp_t          result;
  logic          finish;

  logic [5:0]  e_cat;
  logic [63:0] e_vs, e_vz, e_ps, e_pz;
  assign {e_cat, e_vs, e_vz, e_ps, e_pz} = rd;

  // registered compare stage
  logic        r_wrap, r_hit, r_leaf;
  logic [63:0] r_take;

  logic        take_ok;
  logic [64:0] ve, pe, qv, qp, evend, epend;
  logic [63:0] take_c;
  always_comb begin
    ve    = {1'b0, e_vs} + {1'b0, e_vz};
    pe    = {1'b0, e_ps} + {1'b0, e_pz};
    qv    = {1'b0, cur.virt_addr} + {1'b0, cur.virt_len};
    qp    = {1'b0, cur.phys_addr} + {1'b0, cur.virt_len};
    evend = ve;
    epend = pe;
    take_ok = (e_vs <= cur_v) && (ve[63:0] > cur_v) &&
              (e_ps + (cur_v - e_vs) == cur_p);
    take_c  = ((ve[63:0] - cur_v) > (end_v - cur_v)) ? (end_v - cur_v)
                                                    : (ve[63:0] - cur_v);
  end

  // decide whether the current step ends the query
  always_comb begin
    finish = 1'b0;
    if (cur.opcode == OP_LEAF) begin
      finish = qv[64] || qp[64] || (idx < count && r_leaf) || (idx + 1'b1 >= count);
    end else if (qv[64] || cur_v >= end_v || idx >= count || r_wrap) begin
      finish = 1'b1;
    end else if (r_hit) begin
      finish = (cur_v + r_take >= end_v);
    end else begin
      finish = (idx + 1'b1 >= count);
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.data  = result;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid) begin
        if (req.data.opcode inside {OP_RANGE, OP_LEAF}) state_next = S_READ;
        else state_next = S_DONE;
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: state_next = S_STEP;
      S_STEP:  state_next = finish ? S_DONE : S_READ;
      S_DONE:  if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // table read port
  always_ff @(posedge clk) begin
    rd <= table_mem[idx[IW-1:0]];
    if (state == S_IDLE && req.valid && req.data.opcode == OP_LOAD &&
        count < CW'(MAX_ENTRIES))
      table_mem[count[IW-1:0]] <= {req.data.category, req.data.virt_addr,
        req.data.virt_len, req.data.phys_addr, req.data.phys_len};
  end

  // sequence one query; STEP either finishes it or advances the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (req.valid) begin
          cur      <= req.data;
          cur_v    <= req.data.virt_addr;
          cur_p    <= req.data.phys_addr;
          end_v    <= req.data.virt_addr + req.data.virt_len;
          idx      <= '0;
          result   <= '{covered: 1'b0, status: ST_DONE};
          case (req.data.opcode)
            OP_LOAD: begin
              if (count >= CW'(MAX_ENTRIES)) result.status <= ST_FULL;
              else count <= count + 1'b1;
            end
            OP_CLEAR: count <= '0;
            default: ;
          endcase
        end
        S_CHECK: begin
          r_wrap <= (e_cat == cur.category) && (evend[64] || epend[64]);
          r_hit  <= (e_cat == cur.category) && take_ok;
          r_take <= take_c;
          r_leaf <= (cur.virt_addr >= e_vs) && ({1'b0, cur.virt_addr} + {1'b0, cur.virt_len} <= ve) &&
                    (cur.phys_addr >= e_ps) && ({1'b0, cur.phys_addr} + {1'b0, cur.virt_len} <= pe);
        end
        S_STEP: begin
          if (cur.opcode == OP_LEAF) begin
            if (qv[64] || qp[64]) begin
              result <= '{covered: 1'b0, status: ST_WRAP};
            end else if (idx < count && r_leaf) begin
              result.covered <= 1'b1;
            end else if (idx + 1'b1 < count) begin
              idx <= idx + 1'b1;
            end
          end else begin
            if (qv[64]) begin
              result <= '{covered: 1'b0, status: ST_WRAP};
            end else if (cur_v >= end_v) begin
              result.covered <= 1'b1;
            end else if (idx < count) begin
              if (r_wrap) begin
                result <= '{covered: 1'b0, status: ST_WRAP};
              end else if (r_hit) begin
                cur_v <= cur_v + r_take;
                cur_p <= cur_p + r_take;
                idx   <= '0;
                if (cur_v + r_take >= end_v) result.covered <= 1'b1;
              end else if (idx + 1'b1 < count) begin
                idx <= idx + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/region_table_coverage_checker.sv =====
// Region table coverage checker top level: input queue feeding the engine.
// Depends on rtcc_pkg, the channel interfaces, rtcc_queue and rtcc_engine.
`default_nettype none
// Loads and clears are accepted in the idle state and then hand back the
// response word from the done state. A query walks the region table one
// entry at a time through the read, check and step states and the single
// registered table read port, and a range query restarts its scan after
// each hit. A two-word queue in front accepts words while a query runs.
module region_table_coverage_checker import rtcc_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  rtcc_req_if.sink   in_ch,
  rtcc_rsp_if.source out_ch
);
  rtcc_req_if q2e ();

  rtcc_queue u_queue (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(q2e.source));
  rtcc_engine #(.MAX_ENTRIES(MAX_ENTRIES)) u_engine (
    .clk(clk), .rst(rst), .req(q2e.sink), .rsp(out_ch)
  );
endmodule
`default_nettype wire

// ===== sim/region_table_coverage_checker_test.sv =====
// Self-checking bench for the region table coverage checker: drives load,
// clear and query words and compares every response with a local predictor.
// Depends on rtcc_pkg, rtcc_req_if, rtcc_rsp_if and the checker RTL.
`timescale 1ns / 100ps
module region_table_coverage_checker_test;
  import rtcc_pkg::*;

  localparam int TABLE_DEPTH = 32;

  logic clk;
  logic rst;

  rtcc_req_if in_ch ();
  rtcc_rsp_if out_ch ();

  region_table_coverage_checker #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor copy of the region table
  logic [5:0]  tbl_cat [TABLE_DEPTH];
  logic [63:0] tbl_vs  [TABLE_DEPTH];
  logic [63:0] tbl_vz  [TABLE_DEPTH];
  logic [63:0] tbl_ps  [TABLE_DEPTH];
  logic [63:0] tbl_pz  [TABLE_DEPTH];
  int          tbl_count;

  req_t pending_words [$];
  rsp_t expected_rsps [$];
  int   mismatch_count;
  int   unexpected_count;
  bit   stim_done;
  bit   calm;         // no idling when set
  int   send_gap;
  int   recv_gap;

  // Exact containment of [q, q+len) in [start, start+size)
  function automatic bit region_holds(logic [63:0] start, logic [63:0] size,
                                      logic [63:0] q, logic [63:0] len);
    logic [63:0] off;
    if (q < start) return 0;
    off = q - start;
    if (off > size) return 0;
    return len <= size - off;
  endfunction

  // Follow a same-category chain of regions across the virtual range
  function automatic rsp_t chain_cover(logic [5:0] cat, logic [63:0] va,
                                       logic [63:0] len, logic [63:0] pa);
    rsp_t r;
    logic [63:0] cur_v, cur_p, end_v, ve, pe, take;
    bit advanced;
    r.covered = 0;
    r.status = ST_DONE;
    end_v = va + len;
    if (end_v < va) begin
      r.status = ST_WRAP;
      return r;
    end
    cur_v = va;
    cur_p = pa;
    while (cur_v < end_v) begin
      advanced = 0;
      for (int i = 0; i < tbl_count && !advanced; i++) begin
        if (tbl_cat[i] == cat) begin
          ve = tbl_vs[i] + tbl_vz[i];
          pe = tbl_ps[i] + tbl_pz[i];
          if (ve < tbl_vs[i] || pe < tbl_ps[i]) begin
            r.status = ST_WRAP;
            return r;
          end
          if (!(tbl_vs[i] > cur_v || ve <= cur_v) &&
              tbl_ps[i] + (cur_v - tbl_vs[i]) == cur_p) begin
            take = ve - cur_v;
            if (take > end_v - cur_v) take = end_v - cur_v;
            cur_v += take;
            cur_p += take;
            advanced = 1;
          end
        end
      end
      if (!advanced) return r;
    end
    r.covered = 1;
    return r;
  endfunction

  // Apply one word to the predicted table and return its response
  function automatic rsp_t table_response(req_t w);
    rsp_t r;
    r.covered = 0;
    r.status = ST_DONE;
    case (op_t'(w.opcode))
      OP_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_cat[tbl_count] = w.category;
          tbl_vs[tbl_count] = w.virt_addr;
          tbl_vz[tbl_count] = w.virt_len;
          tbl_ps[tbl_count] = w.phys_addr;
          tbl_pz[tbl_count] = w.phys_len;
          tbl_count++;
        end
      end
      OP_CLEAR: tbl_count = 0;
      OP_RANGE: r = chain_cover(w.category, w.virt_addr, w.virt_len, w.phys_addr);
      default: begin
        if (w.virt_addr + w.virt_len < w.virt_addr ||
            w.phys_addr + w.virt_len < w.phys_addr) begin
          r.status = ST_WRAP;
        end else begin
          for (int i = 0; i < tbl_count; i++)
            if (region_holds(tbl_vs[i], tbl_vz[i], w.virt_addr, w.virt_len) &&
                region_holds(tbl_ps[i], tbl_pz[i], w.phys_addr, w.virt_len))
              r.covered = 1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_word(op_t op, logic [5:0] cat, logic [63:0] va,
                                     logic [63:0] vl, logic [63:0] pa,
                                     logic [63:0] pl);
    req_t w;
    w.opcode = op;
    w.category = cat;
    w.virt_addr = va;
    w.virt_len = vl;
    w.phys_addr = pa;
    w.phys_len = pl;
    return w;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Driver: present queued words, with bursts of idle cycles
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(table_response(in_ch.data));
        void'(pending_words.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap <= int'($urandom_range(0, 9));
        in_ch.valid <= 0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid <= 1;
        in_ch.data <= pending_words[0];
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Monitor: accept responses with bursts of stall and check them in order
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          unexpected_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("unexpected response word covered=%0b status=%0d",
                     out_ch.data.covered, out_ch.data.status);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (e.covered !== out_ch.data.covered || e.status !== out_ch.data.status) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= 10)
              $display("mismatch: expected covered=%0b status=%0d, got covered=%0b status=%0d",
                       e.covered, e.status, out_ch.data.covered, out_ch.data.status);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap <= int'($urandom_range(0, 9));
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Build a contiguous chain of regions in one category, then query it
  task automatic queue_chain_set();
    logic [5:0]  cat;
    logic [63:0] base_v, base_p, cur_v, cur_p, sz, span;
    int n;
    cat = 6'($urandom_range(0, 3));
    base_v = ($urandom_range(0, 1)) ? rand64() >> 2 : 64'($urandom_range(0, 4096));
    base_p = ($urandom_range(0, 1)) ? rand64() >> 2 : 64'($urandom_range(0, 4096));
    n = int'($urandom_range(1, 4));
    pending_words.push_back(make_word(OP_CLEAR, 6'd0, 64'd0, 64'd0, 64'd0, 64'd0));
    cur_v = base_v;
    cur_p = base_p;
    // distractor entries of other categories or mismatched physical base
    for (int i = 0; i < $urandom_range(0, 3); i++)
      pending_words.push_back(make_word(OP_LOAD, 6'($urandom_range(0, 63)),
        base_v + 64'($urandom_range(0, 64)), 64'($urandom_range(1, 256)),
        base_p + 64'($urandom_range(0, 64)), 64'($urandom_range(1, 256))));
    for (int i = 0; i < n; i++) begin
      sz = 64'($urandom_range(1, 256));
      pending_words.push_back(make_word(OP_LOAD, cat, cur_v, sz,
        ($urandom_range(0, 9) == 0) ? cur_p + 64'd1 : cur_p,
        sz + 64'($urandom_range(0, 2))));
      cur_v += sz;
      cur_p += sz;
    end
    // occasional wrapping entry of the same category
    if ($urandom_range(0, 9) == 0)
      pending_words.push_back(make_word(OP_LOAD, cat, rand64() | 64'hF000_0000_0000_0000,
        rand64() | 64'hF000_0000_0000_0000, rand64(), rand64()));
    span = cur_v - base_v;
    for (int q = 0; q < $urandom_range(3, 8); q++) begin
      logic [63:0] off, len;
      off = $urandom_range(0, 3) == 0 ? 64'd0 : 64'($urandom_range(0, int'(span)));
      len = $urandom_range(0, 3) == 0 ? span - off
            : 64'($urandom_range(0, int'(span - off) + 2));
      pending_words.push_back(make_word($urandom_range(0, 1) ? OP_RANGE : OP_LEAF,
        $urandom_range(0, 4) == 0 ? 6'($urandom) : cat,
        base_v + off, len, base_p + off + 64'($urandom_range(0, 7) == 0), 64'd0));
    end
  endtask

  initial begin
    req_t w;
    mismatch_count = 0;
    unexpected_count = 0;
    stim_done = 0;
    calm = 0;
    tbl_count = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: extremes, every opcode, wrap and zero-size cases
    pending_words.push_back(make_word(OP_RANGE, 6'd0, 64'd100, 64'd0, 64'd5, 64'd0));
    pending_words.push_back(make_word(OP_LEAF, 6'd63, '1, '1, '1, '1));
    pending_words.push_back(make_word(OP_LOAD, 6'd63, '1, '1, '1, '1));
    pending_words.push_back(make_word(OP_LOAD, 6'd0, 64'h1000, 64'h100, 64'h8000, 64'h100));
    pending_words.push_back(make_word(OP_RANGE, 6'd63, 64'h10, 64'h10, 64'h0, 64'h0));
    pending_words.push_back(make_word(OP_RANGE, 6'd0, '1, 64'd2, 64'h0, 64'h0));
    pending_words.push_back(make_word(OP_RANGE, 6'd0, 64'h1000, 64'h100, 64'h8000, 64'h0));
    pending_words.push_back(make_word(OP_LEAF, 6'd0, 64'h1010, 64'h10, 64'h8010, 64'h0));
    pending_words.push_back(make_word(OP_LEAF, 6'd0, 64'h10, 64'h10, '1, 64'h0));
    pending_words.push_back(make_word(OP_LEAF, 6'd0, 64'h1000, 64'h0, 64'h8100, 64'h0));
    pending_words.push_back(make_word(OP_CLEAR, 6'd63, '1, '1, '1, '1));
    for (int i = 0; i < TABLE_DEPTH + 1; i++)
      pending_words.push_back(make_word(OP_LOAD, 6'(i), 64'(i) << 8, 64'h100,
                                        64'(i) << 12, 64'h100));
    pending_words.push_back(make_word(OP_RANGE, 6'd5, 64'h500, 64'h100, 64'h5000, 64'h0));
    pending_words.push_back(make_word(OP_LEAF, 6'd0, 64'h1f80, 64'h80, 64'h1f080, 64'h0));
    pending_words.push_back(make_word(OP_CLEAR, 6'd0, 64'd0, 64'd0, 64'd0, 64'd0));

    // Random: mostly chained region sets, some pure noise words
    while (pending_words.size() < 1900) begin
      if ($urandom_range(0, 4) == 0) begin
        w = {rand64(), rand64(), rand64(), rand64(), 8'($urandom)};
        pending_words.push_back(w);
      end else begin
        queue_chain_set();
      end
    end

    // stop idling for the last part of the run
    wait (pending_words.size() < 300);
    calm = 1;
    wait (pending_words.size() == 0);
    stim_done = 1;
    wait (expected_rsps.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && unexpected_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: ends the run with a failure report if it has not finished
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
